>>> rtl/assert_macros.svh
// assertion macros for the sound generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/ttsg_pkg.sv
// ------------------------------------------------------------------
// ttsg_pkg
// shared types and constants of the timer and tone sound generator
// ------------------------------------------------------------------
package ttsg_pkg;
	localparam int MAX_CLOCKS_DEF  = 64;
	localparam int PHASE_BITS_DEF  = 24;
	localparam int UNIT_VOLUME_DEF = 5461;
	localparam logic [29:0] CPS_RESET   = 30'd340446622;
	localparam logic [31:0] SCALE_RESET = 32'd680893175;
	localparam logic [15:0] LFSR_RESET  = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS   = 16'hB400;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_TIMER  = 2'd1,
		CMD_TONE   = 2'd2,
		CMD_EFFECT = 2'd3
	} cmd_t;

	localparam logic CFG_CPS   = 1'b0;
	localparam logic CFG_SCALE = 1'b1;

	typedef struct packed {
		cmd_t       cmd;
		logic [2:0] off;
		logic [7:0] data;
	} item_t;
endpackage

>>> rtl/timer_tone_sound_generator_core.sv
// ------------------------------------------------------------------
// timer_tone_sound_generator_core
// three timers, noise source and three tone dividers mixed to one sample
// ------------------------------------------------------------------
// channel   direction  handshake        payload
// input     in         push / full      command, reg_offset, write_data
// result    out        empty / pop      sample
// config    in         cfg_we           cfg_index, cfg_data
// a tick is worked off by the engine, which walks the noise source and steps
// the timers one clock per cycle
// a tone high-byte write runs through the shared divider
// other writes are done in the idle state; a two-entry queue decouples the input
// reset clears control state and registers at once, not queue storage or divider data; no clearing pass
module timer_tone_sound_generator_core #(
	parameter int MAX_CLOCKS  = ttsg_pkg::MAX_CLOCKS_DEF,
	parameter int PHASE_BITS  = ttsg_pkg::PHASE_BITS_DEF,
	parameter int UNIT_VOLUME = ttsg_pkg::UNIT_VOLUME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [2:0]  reg_offset,
	input  logic [7:0]  write_data,
	output logic        empty,
	input  logic        pop,
	output logic [14:0] sample,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
`include "assert_macros.svh"
	ttsg_pkg::item_t in_item, head;
	logic avail, take, res_valid;
	logic [29:0] cps_q;
	logic [31:0] scale_q;

	assign in_item = '{cmd: ttsg_pkg::cmd_t'(command), off: reg_offset, data: write_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cps_q <= ttsg_pkg::CPS_RESET;
			scale_q <= ttsg_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ttsg_pkg::CFG_CPS) cps_q <= cfg_data[29:0];
			else scale_q <= cfg_data;
		end
	end

	ttsg_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.avail(avail), .take(take), .head(head)
	);

	ttsg_engine #(
		.MAX_CLOCKS(MAX_CLOCKS), .PHASE_BITS(PHASE_BITS), .UNIT_VOLUME(UNIT_VOLUME)
	) u_engine (
		.clk(clk), .arst_n(arst_n), .avail(avail), .take(take), .item(head),
		.cps(cps_q), .scale(scale_q), .res_valid(res_valid), .res_sample(sample),
		.res_room(pop)
	);

	assign empty = !res_valid;

	`ASSERT_IMPLIES(a_take_needs_avail, clk, arst_n, take, avail)
	`ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(sample))
	`ASSERT_NEXT(a_full_blocks, clk, arst_n, full && !take, full)
endmodule

>>> rtl/ttsg_front.sv
// ------------------------------------------------------------------
// ttsg_front
// input queue: accepts items and holds them for the engine
// ------------------------------------------------------------------
module ttsg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  ttsg_pkg::item_t      in_item,
	output logic                 avail,
	input  logic                 take,
	output ttsg_pkg::item_t      head
);
	ttsg_pkg::item_t mem_q [2];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (take && avail) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, take && avail};
		end
	end
endmodule

>>> rtl/ttsg_div.sv
// ------------------------------------------------------------------
// ttsg_div
// radix-2 restoring divider, one quotient bit per cycle
// ------------------------------------------------------------------
module ttsg_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        busy,
	output logic [31:0] quo
);
	logic [5:0]  cnt_q;
	logic [31:0] q_q;
	logic [15:0] r_q;
	logic [15:0] d_q;
	logic [16:0] trial;

	assign busy = (cnt_q != 6'd0);
	assign quo  = q_q;
	assign trial = {r_q, q_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// remainder stays below the divisor, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= 16'(trial - {1'b0, d_q});
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= trial[15:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/ttsg_engine.sv
// ------------------------------------------------------------------
// ttsg_engine
// back end: register writes and the per-tick timer, noise and tone walk
// ------------------------------------------------------------------
module ttsg_engine #(
	parameter int MAX_CLOCKS  = ttsg_pkg::MAX_CLOCKS_DEF,
	parameter int PHASE_BITS  = ttsg_pkg::PHASE_BITS_DEF,
	parameter int UNIT_VOLUME = ttsg_pkg::UNIT_VOLUME_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            avail,
	output logic            take,
	input  ttsg_pkg::item_t item,
	input  logic [29:0]     cps,
	input  logic [31:0]     scale,
	output logic            res_valid,
	output logic [14:0]     res_sample,
	input  logic            res_room
);
	localparam int CW = 8;
	localparam logic [CW-1:0] MAXC = CW'(MAX_CLOCKS);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DIV    = 9'b000000010,
		S_NOISE  = 9'b000000100,
		S_T0     = 9'b000001000,
		S_NOISE2 = 9'b000010000,
		S_T1     = 9'b000100000,
		S_T2     = 9'b001000000,
		S_TONE   = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;
	state_t st_q;

	logic [7:0]  tctl_q [3];
	logic [15:0] trl_q [3];
	logic [15:0] tcnt_q [3];
	logic [2:0]  tout_q;
	logic [15:0] tedge_q [3];
	logic [2:0]  pre_q;
	logic [7:0]  msb_q;
	logic [12:0] vol_q [3];
	logic [7:0]  eff_q;
	logic        nlev_q;
	logic [1:0]  nhist_q;
	logic [15:0] lfsr_q;
	logic [PHASE_BITS-1:0] sph_q;
	logic [2:0]  tog_q;
	logic [15:0] tdiv_q [3];
	logic [2:0]  ten_q;
	logic [31:0] tstep_q [3];
	logic [23:0] tph_q [3];

	logic [CW-1:0] clocks_q, nclk_q, rem_q, nedge_q;
	logic [8:0]    nsteps_q;
	logic [15:0]   edges0_q;
	logic [14:0]   sum_q;
	logic [1:0]    dch_q, tch_q;
	logic          ts_lo_q;

	logic        div_start, div_busy;
	logic [31:0] div_quo;
	logic [15:0] div_den;

	ttsg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(scale),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	logic noisy;
	assign noisy = ((tctl_q[0] & tctl_q[1] & tctl_q[2] & 8'h02) == 8'h00);
	assign take = (st_q == S_IDLE) && avail;

	// phase add, saturated whole part
	logic [30:0] ph_sum;
	logic [30:0] whole;
	logic [CW-1:0] clk_sat;
	assign ph_sum = 31'(sph_q) + {1'b0, cps};
	assign whole  = ph_sum >> PHASE_BITS;
	assign clk_sat = (whole > 31'(MAX_CLOCKS)) ? MAXC : CW'(whole);

	// one timer, one clock step
	logic [1:0]  tsel;
	logic [15:0] w_cur, w_nx, rl;
	logic        o_nx, edge_inc, t_dual;
	logic [7:0]  lo, hi;
	always_comb begin
		unique case (st_q)
			S_T0:    tsel = 2'd0;
			S_T1:    tsel = 2'd1;
			default: tsel = 2'd2;
		endcase
		w_cur = tcnt_q[tsel];
		rl = trl_q[tsel];
		t_dual = tctl_q[tsel][2];
		lo = w_cur[7:0];
		hi = w_cur[15:8];
		o_nx = tout_q[tsel];
		edge_inc = 1'b0;
		w_nx = w_cur - 16'd1;
		if (t_dual) begin
			if (lo == 8'd0) begin
				if (hi == 8'd0) begin
					o_nx = 1'b0;
					w_nx = rl;
				end else begin
					w_nx = {hi - 8'd1, rl[7:0]};
					if (hi == 8'd1) begin
						o_nx = 1'b1;
						edge_inc = 1'b1;
					end
				end
			end
		end else if (w_cur == 16'd0) begin
			o_nx = ~tout_q[tsel];
			edge_inc = o_nx;
			w_nx = rl;
		end
	end

	logic lf_bit, nl_nx;
	logic [1:0] nh_nx;
	assign lf_bit = lfsr_q[0];
	assign nh_nx  = {nhist_q[0], lf_bit};
	assign nl_nx  = (nh_nx == 2'b01) ? ~nlev_q : nlev_q;

	logic [15:0] edelta;
	assign edelta = tedge_q[0] - edges0_q;

	logic [CW+2:0] pc;
	logic [CW-1:0] c2;
	always_comb begin
		pc = (tctl_q[2][1] ? {3'd0, clocks_q} : {3'd0, nclk_q}) + {{CW{1'b0}}, pre_q};
		c2 = tctl_q[2][0] ? CW'(pc >> 3)
			: (tctl_q[2][1] ? clocks_q : nclk_q);
	end

	logic [23:0] tph_nx;
	assign tph_nx = tph_q[tch_q] + tstep_q[tch_q][23:0];

	// volume steps: level times unit volume over seven
	logic [12:0] vol_lut;
	always_comb begin
		unique case (item.data[2:0])
			3'd0: vol_lut = 13'((0 * UNIT_VOLUME) / 7);
			3'd1: vol_lut = 13'((1 * UNIT_VOLUME) / 7);
			3'd2: vol_lut = 13'((2 * UNIT_VOLUME) / 7);
			3'd3: vol_lut = 13'((3 * UNIT_VOLUME) / 7);
			3'd4: vol_lut = 13'((4 * UNIT_VOLUME) / 7);
			3'd5: vol_lut = 13'((5 * UNIT_VOLUME) / 7);
			3'd6: vol_lut = 13'((6 * UNIT_VOLUME) / 7);
			default: vol_lut = 13'((7 * UNIT_VOLUME) / 7);
		endcase
	end

	assign div_start = take && item.cmd == ttsg_pkg::CMD_TONE &&
		item.off[1:0] != 2'd3 && tog_q[item.off[1:0]];
	assign div_den = {item.data, tdiv_q[item.off[1:0]][7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			for (int i = 0; i < 3; i++) begin
				tctl_q[i] <= '0; trl_q[i] <= '0; tcnt_q[i] <= '0; vol_q[i] <= '0;
				tedge_q[i] <= '0; tdiv_q[i] <= '0; tstep_q[i] <= '0; tph_q[i] <= '0;
			end
			tout_q <= '0; pre_q <= '0; msb_q <= '0; eff_q <= '0;
			nlev_q <= 1'b0; nhist_q <= '0; lfsr_q <= ttsg_pkg::LFSR_RESET;
			sph_q <= '0; tog_q <= '0; ten_q <= '0;
			clocks_q <= '0; nclk_q <= '0; rem_q <= '0; nedge_q <= '0;
			nsteps_q <= '0; edges0_q <= '0; sum_q <= '0; dch_q <= '0;
			tch_q <= '0; ts_lo_q <= 1'b0; res_valid <= 1'b0; res_sample <= '0;
		end else begin
			if (res_valid && res_room) res_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (take) begin
					unique case (item.cmd)
						ttsg_pkg::CMD_TICK: begin
							sph_q <= ph_sum[PHASE_BITS-1:0];
							clocks_q <= clk_sat;
							sum_q <= '0;
							nclk_q <= '0;
							nedge_q <= '0;
							edges0_q <= tedge_q[0];
							nsteps_q <= {clk_sat, 1'b0};
							if (tctl_q[0][0]) begin
								tch_q <= 2'd0;
								st_q <= S_TONE;
							end else if (noisy && !eff_q[0]) begin
								st_q <= S_NOISE;
							end else begin
								st_q <= S_T0;
								rem_q <= tctl_q[0][1] ? clk_sat : '0;
							end
						end
						ttsg_pkg::CMD_TIMER: begin
							unique case (item.off)
								3'd0: if (tctl_q[1][0]) tctl_q[0] <= item.data;
									else tctl_q[2] <= item.data;
								3'd1: tctl_q[1] <= item.data;
								3'd2, 3'd4, 3'd6: msb_q <= item.data;
								default: begin
									trl_q[item.off[2:1] - 2'd1] <= {msb_q, item.data};
									tcnt_q[item.off[2:1] - 2'd1] <= {msb_q, item.data};
								end
							endcase
						end
						ttsg_pkg::CMD_TONE: begin
							if (item.off[1:0] == 2'd3) begin
								if (item.data[7:6] != 2'd3)
									ten_q[item.data[7:6]] <= (item.data[3:1] != 3'd0);
							end else if (!tog_q[item.off[1:0]]) begin
								tog_q[item.off[1:0]] <= 1'b1;
								tdiv_q[item.off[1:0]][7:0] <= item.data;
							end else begin
								tog_q[item.off[1:0]] <= 1'b0;
								tdiv_q[item.off[1:0]][15:8] <= item.data;
								dch_q <= item.off[1:0];
								ts_lo_q <= (div_den == 16'd0);
								st_q <= S_DIV;
							end
						end
						default: begin
							if (item.off[1:0] == 2'd0) eff_q <= item.data;
							else vol_q[item.off[1:0] - 2'd1] <= vol_lut;
						end
					endcase
				end
				S_DIV: if (!div_busy) begin
					tstep_q[dch_q] <= ts_lo_q ? 32'd0 : div_quo;
					st_q <= S_IDLE;
				end
				S_NOISE, S_NOISE2: begin
					if (nsteps_q != 9'd0) begin
						lfsr_q <= (lfsr_q >> 1) ^ (lf_bit ? ttsg_pkg::LFSR_TAPS : 16'd0);
						nhist_q <= nh_nx;
						nlev_q <= nl_nx;
						if (nh_nx == 2'b01 && nl_nx) nedge_q <= nedge_q + 1'b1;
						nsteps_q <= nsteps_q - 9'd1;
					end else begin
						nclk_q <= nedge_q;
						if (st_q == S_NOISE) begin
							st_q <= S_T0;
							rem_q <= tctl_q[0][1] ? clocks_q : nedge_q;
						end else begin
							st_q <= S_T1;
							rem_q <= tctl_q[1][1] ? clocks_q : nedge_q;
						end
					end
				end
				S_T0, S_T1, S_T2: begin
					if (tctl_q[tsel][7] && rem_q != '0) begin
						tcnt_q[tsel] <= w_nx;
						tout_q[tsel] <= o_nx;
						if (edge_inc) tedge_q[tsel] <= tedge_q[tsel] + 16'd1;
						rem_q <= rem_q - 1'b1;
					end else begin
						if (tctl_q[tsel][7] && tout_q[tsel] &&
						    !(st_q == S_T0 && eff_q[1]))
							sum_q <= sum_q + {2'd0, vol_q[tsel]};
						unique case (st_q)
							S_T0: if (noisy && eff_q[0]) begin
								st_q <= S_NOISE2;
								nedge_q <= '0;
								nsteps_q <= (edelta > 16'(MAX_CLOCKS)) ?
									{MAXC, 1'b0} : {edelta[CW-1:0], 1'b0};
							end else begin
								st_q <= S_T1;
								rem_q <= tctl_q[1][1] ? clocks_q : nclk_q;
							end
							S_T1: begin
								st_q <= S_T2;
								rem_q <= c2;
								if (tctl_q[2][7] && tctl_q[2][0]) pre_q <= pc[2:0];
							end
							default: begin
								st_q <= S_TONE;
								tch_q <= 2'd0;
							end
						endcase
					end
				end
				S_TONE: begin
					if (ten_q[tch_q]) begin
						tph_q[tch_q] <= tph_nx;
						if (tph_nx[23]) sum_q <= sum_q + 15'(UNIT_VOLUME);
					end
					if (tch_q == 2'd2) st_q <= S_OUT;
					else tch_q <= tch_q + 2'd1;
				end
				default: if (!res_valid) begin
					res_valid <= 1'b1;
					res_sample <= sum_q;
					st_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------
// tb
// bench for the timer and tone sound generator: bus writes and sample
// ticks go in through the input queue, every sample is checked against
// an in-bench model of timers, noise source and tone dividers
// ------------------------------------------------------------------
class sound_scoreboard;
	int unsigned cps, scale;
	int unsigned tctl[3], trel[3], tcnt[3], tout[3], tedges[3];
	int unsigned pre_rem, msb, vol[3], fx, nlevel, nhist, lfsr, phase;
	int unsigned toggle[3], divisor[3], tenable[3], tstep[3], tphase[3];
	logic [14:0] sample_q[$];
	int unsigned ticks, writes;

	function new();
		cps = ttsg_pkg::CPS_RESET;
		scale = ttsg_pkg::SCALE_RESET;
		for (int k = 0; k < 3; k++) begin
			tctl[k] = 0; trel[k] = 0; tcnt[k] = 0; tout[k] = 0; tedges[k] = 0;
			vol[k] = 0; toggle[k] = 0; divisor[k] = 0; tenable[k] = 0;
			tstep[k] = 0; tphase[k] = 0;
		end
		pre_rem = 0; msb = 0; fx = 0; nlevel = 0; nhist = 0;
		lfsr = ttsg_pkg::LFSR_RESET; phase = 0; ticks = 0; writes = 0;
	endfunction

	function void set_reg(logic idx, int unsigned v);
		if (idx == ttsg_pkg::CFG_CPS)
			cps = v & 32'h3FFF_FFFF;
		else
			scale = v;
	endfunction

	// two lfsr steps per clock, returns rising edges of the noise level
	function int unsigned noise_run(int unsigned n);
		int unsigned rises, b;
		rises = 0;
		for (int unsigned i = 0; i < 2 * n; i++) begin
			b = lfsr & 1;
			lfsr = lfsr >> 1;
			if (b != 0)
				lfsr = lfsr ^ ttsg_pkg::LFSR_TAPS;
			nhist = ((nhist << 1) | b) & 3;
			if (nhist == 1) begin
				nlevel = nlevel ^ 1;
				rises += nlevel;
			end
		end
		return rises;
	endfunction

	function void timer_run(int k, int unsigned c);
		int unsigned w, rl, lo, hi;
		w = tcnt[k];
		rl = trel[k];
		if ((tctl[k] & 8'h04) != 0) begin
			lo = w & 8'hFF;
			hi = (w >> 8) & 8'hFF;
			while (c > lo) begin
				c -= lo + 1;
				lo = rl & 8'hFF;
				if (hi == 0) begin
					tout[k] = 0;
					hi = (rl >> 8) & 8'hFF;
				end else begin
					hi--;
					if (hi == 0) begin
						tout[k] = 1;
						tedges[k] = (tedges[k] + 1) & 16'hFFFF;
					end
				end
			end
			lo -= c;
			w = (hi << 8) | (lo & 8'hFF);
		end else begin
			while (c > w) begin
				c -= w + 1;
				tout[k] ^= 1;
				tedges[k] = (tedges[k] + tout[k]) & 16'hFFFF;
				w = rl;
			end
			w -= c;
		end
		tcnt[k] = w & 16'hFFFF;
	endfunction

	function int unsigned pick_clocks(int k, int unsigned direct, int unsigned nclk);
		return ((tctl[k] & 8'h02) != 0) ? direct : nclk;
	endfunction

	function logic [14:0] tick_sample();
		longint unsigned ph;
		int unsigned clocks, nclk, edges0, d, c, sum;
		bit noisy;
		sum = 0;
		ph = longint'(phase) + cps;
		clocks = ((ph >> ttsg_pkg::PHASE_BITS_DEF) > ttsg_pkg::MAX_CLOCKS_DEF)
			? ttsg_pkg::MAX_CLOCKS_DEF : int'(ph >> ttsg_pkg::PHASE_BITS_DEF);
		phase = 32'(ph & ((64'd1 << ttsg_pkg::PHASE_BITS_DEF) - 1));
		noisy = ((tctl[0] & tctl[1] & tctl[2] & 8'h02) == 0);
		if ((tctl[0] & 8'h01) == 0) begin
			nclk = 0;
			edges0 = tedges[0];
			if (noisy && (fx & 1) == 0)
				nclk = noise_run(clocks);
			if ((tctl[0] & 8'h80) != 0) begin
				timer_run(0, pick_clocks(0, clocks, nclk));
				if (tout[0] != 0 && (fx & 8'h02) == 0)
					sum += vol[0];
			end
			// noise clocked by timer 0 edges
			if (noisy && (fx & 1) != 0) begin
				d = (tedges[0] - edges0) & 16'hFFFF;
				if (d > ttsg_pkg::MAX_CLOCKS_DEF)
					d = ttsg_pkg::MAX_CLOCKS_DEF;
				nclk = noise_run(d);
			end
			if ((tctl[1] & 8'h80) != 0) begin
				timer_run(1, pick_clocks(1, clocks, nclk));
				if (tout[1] != 0)
					sum += vol[1];
			end
			if ((tctl[2] & 8'h80) != 0) begin
				c = pick_clocks(2, clocks, nclk);
				if ((tctl[2] & 8'h01) != 0) begin
					c += pre_rem;
					pre_rem = c & 7;
					c = c >> 3;
				end
				timer_run(2, c);
				if (tout[2] != 0)
					sum += vol[2];
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (tenable[k] != 0) begin
				tphase[k] = (tphase[k] + tstep[k]) & 24'hFFFFFF;
				if ((tphase[k] & 24'h800000) != 0)
					sum += ttsg_pkg::UNIT_VOLUME_DEF;
			end
		end
		return sum[14:0];
	endfunction

	function void note_item(ttsg_pkg::cmd_t c, logic [2:0] off, logic [7:0] d);
		int unsigned o, ch;
		o = off & 3;
		case (c)
			ttsg_pkg::CMD_TICK: begin
				sample_q.push_back(tick_sample());
				ticks++;
			end
			ttsg_pkg::CMD_TIMER: begin
				case (off)
					3'd0: begin
						if ((tctl[1] & 1) != 0)
							tctl[0] = d;
						else
							tctl[2] = d;
					end
					3'd1: tctl[1] = d;
					3'd2, 3'd4, 3'd6: msb = d;
					default: begin
						ch = (off - 3) >> 1;
						trel[ch] = ((msb << 8) | d) & 16'hFFFF;
						tcnt[ch] = trel[ch];
					end
				endcase
			end
			ttsg_pkg::CMD_TONE: begin
				if (o < 3) begin
					if (toggle[o] == 0) begin
						toggle[o] = 1;
						divisor[o] = (divisor[o] & 16'hFF00) | d;
					end else begin
						toggle[o] = 0;
						divisor[o] = (divisor[o] & 16'h00FF) | (int'(d) << 8);
						tstep[o] = (divisor[o] != 0) ? scale / divisor[o] : 0;
					end
				end else begin
					ch = d[7:6];
					if (ch < 3)
						tenable[ch] = ((d & 8'h0E) != 0);
				end
			end
			default: begin
				if (o == 0)
					fx = d;
				else
					vol[o - 1] = ((d & 7) * ttsg_pkg::UNIT_VOLUME_DEF) / 7;
			end
		endcase
		if (c != ttsg_pkg::CMD_TICK)
			writes++;
	endfunction

	function bit check(logic [14:0] got, output string why);
		logic [14:0] want;
		if (sample_q.size() == 0) begin
			why = $sformatf("sample %0d with none expected", got);
			return 0;
		end
		want = sample_q.pop_front();
		why = $sformatf("sample %0d, expected %0d", got, want);
		return got === want;
	endfunction
endclass

module tb;
	logic clk, arst_n, push, full, empty, pop, cfg_we, cfg_index;
	logic [1:0] command;
	logic [2:0] reg_offset;
	logic [7:0] write_data;
	logic [14:0] sample;
	logic [31:0] cfg_data;

	sound_scoreboard board;
	int fail_count;
	int checked;
	int send_idle_pct, pop_stall_pct;

	timer_tone_sound_generator_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.command(command), .reg_offset(reg_offset), .write_data(write_data),
		.empty(empty), .pop(pop), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("simulation failed");
		$finish;
	end

	task report_mismatch(string why);
		$display("mismatch at %0t: %s", $realtime, why);
		fail_count++;
	endtask

	// result side
	always @(negedge clk)
		pop = ($urandom_range(0, 99) >= pop_stall_pct);

	always @(posedge clk) begin
		string why;
		if (arst_n && pop && !empty) begin
			checked++;
			if (!board.check(sample, why))
				report_mismatch(why);
		end
	end

	task send_item(ttsg_pkg::cmd_t c, logic [2:0] o, logic [7:0] d);
		bit done;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		command = c;
		reg_offset = o;
		write_data = d;
		push = 1'b1;
		done = 0;
		while (!done) begin
			@(posedge clk);
			if (!full) begin
				board.note_item(c, o, d);
				done = 1;
			end
			@(negedge clk);
		end
	endtask

	task drain();
		push = 1'b0;
		while (board.sample_q.size() != 0)
			@(negedge clk);
		// a tone divide or tick may still be running
		repeat (400) @(negedge clk);
	endtask

	task write_reg(logic idx, logic [31:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		board.set_reg(idx, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task random_item();
		ttsg_pkg::cmd_t c;
		logic [2:0] o;
		logic [7:0] d;
		int r;
		r = $urandom_range(0, 99);
		o = $urandom_range(0, 7);
		d = $urandom_range(0, 255);
		if (r < 40)
			c = ttsg_pkg::CMD_TICK;
		else if (r < 65) begin
			c = ttsg_pkg::CMD_TIMER;
			// keep timers mostly running and mostly enabled
			if (o == 3'd0 && $urandom_range(0, 9) < 6)
				d[0] = 1'b0;
			if (o <= 3'd1 && $urandom_range(0, 3) != 0)
				d[7] = 1'b1;
			if ((o == 3'd2 || o == 3'd4 || o == 3'd6) && $urandom_range(0, 1) == 0)
				d = $urandom_range(0, 3);
		end else if (r < 82)
			c = ttsg_pkg::CMD_TONE;
		else
			c = ttsg_pkg::CMD_EFFECT;
		send_item(c, o, d);
	endtask

	initial begin
		board = new();
		fail_count = 0;
		checked = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		arst_n = 1'b0;
		push = 1'b0;
		command = ttsg_pkg::CMD_TICK;
		reg_offset = '0;
		write_data = '0;
		cfg_we = 1'b0;
		cfg_index = ttsg_pkg::CFG_CPS;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: volumes, tones, timer modes, hold and zero divisor
		send_item(ttsg_pkg::CMD_TICK, 3'd0, 8'h00);
		send_item(ttsg_pkg::CMD_EFFECT, 3'd1, 8'hFF);
		send_item(ttsg_pkg::CMD_EFFECT, 3'd2, 8'h07);
		send_item(ttsg_pkg::CMD_EFFECT, 3'd7, 8'h03);
		send_item(ttsg_pkg::CMD_TONE, 3'd0, 8'h00);
		send_item(ttsg_pkg::CMD_TONE, 3'd0, 8'h01);
		send_item(ttsg_pkg::CMD_TONE, 3'd1, 8'h00);
		send_item(ttsg_pkg::CMD_TONE, 3'd5, 8'h00);
		send_item(ttsg_pkg::CMD_TONE, 3'd3, 8'h02);
		send_item(ttsg_pkg::CMD_TONE, 3'd7, 8'h4E);
		send_item(ttsg_pkg::CMD_TONE, 3'd3, 8'hCE);
		send_item(ttsg_pkg::CMD_TIMER, 3'd1, 8'h82);
		send_item(ttsg_pkg::CMD_TIMER, 3'd0, 8'h87);
		send_item(ttsg_pkg::CMD_TIMER, 3'd6, 8'h01);
		send_item(ttsg_pkg::CMD_TIMER, 3'd7, 8'h02);
		send_item(ttsg_pkg::CMD_TIMER, 3'd3, 8'hFF);
		send_item(ttsg_pkg::CMD_TIMER, 3'd1, 8'h83);
		send_item(ttsg_pkg::CMD_TIMER, 3'd0, 8'h80);
		send_item(ttsg_pkg::CMD_TICK, 3'd0, 8'h00);
		send_item(ttsg_pkg::CMD_EFFECT, 3'd0, 8'h03);
		send_item(ttsg_pkg::CMD_TICK, 3'd0, 8'h00);
		send_item(ttsg_pkg::CMD_TIMER, 3'd0, 8'h81);
		send_item(ttsg_pkg::CMD_TICK, 3'd0, 8'h00);
		drain();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 65; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 65; end
				3: begin send_idle_pct = 36; pop_stall_pct = 36; end
				default: begin send_idle_pct = 0; pop_stall_pct = 0; end
			endcase
			case (p)
				1: begin
					write_reg(ttsg_pkg::CFG_CPS, 32'h3FFF_FFFF);
					write_reg(ttsg_pkg::CFG_SCALE, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(ttsg_pkg::CFG_CPS, 32'd0);
					write_reg(ttsg_pkg::CFG_SCALE, 32'd0);
				end
				3: begin
					write_reg(ttsg_pkg::CFG_CPS, $urandom_range(0, 32'h3FFF_FFFF));
					write_reg(ttsg_pkg::CFG_SCALE, $urandom);
				end
				4: begin
					write_reg(ttsg_pkg::CFG_CPS, 32'(ttsg_pkg::CPS_RESET));
					write_reg(ttsg_pkg::CFG_SCALE, ttsg_pkg::SCALE_RESET);
				end
				default: ;
			endcase
			for (int n = 0; n < 240; n++) begin
				random_item();
				// hold off until the result queue has emptied
				if (p == 3 && n == 120)
					drain();
			end
			drain();
		end

		$display("items: %0d ticks, %0d register writes, %0d samples checked",
			board.ticks, board.writes, checked);
		$display("covered five idle/stall mixes and cps/scale at zero, max and reset");
		if (fail_count == 0 && board.sample_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
